FILE: rtl/flow_heatmap_color_unit_macros.svh
// assertion macros for the heat colormap block
// expects clk and rst_n in scope at the point of use
`ifndef FLOW_HEATMAP_COLOR_UNIT_MACROS_SVH
`define FLOW_HEATMAP_COLOR_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fhc_pkg.sv
// shared types and constants of the heat colormap block
// no dependencies
`default_nettype none

package fhc_pkg;

  // register indexes on the config port
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_LEVEL = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LEVEL  = 3'd3;

  // threshold reset values, truncated to the sample width at use
  localparam logic [31:0] RST_MIN_LEVEL  = 32'd0;
  localparam logic [31:0] RST_LOW_LEVEL  = 32'd10922;
  localparam logic [31:0] RST_HIGH_LEVEL = 32'd21845;
  localparam logic [31:0] RST_MAX_LEVEL  = 32'd32767;

  // colour segment selected for a sample
  typedef enum logic [2:0] {
    MODE_BLUE    = 3'd0,
    MODE_RED     = 3'd1,
    MODE_G_UP    = 3'd2,
    MODE_G_DOWN  = 3'd3,
    MODE_B_DOWN  = 3'd4,
    MODE_R_UP    = 3'd5
  } fhc_mode_t;

endpackage

`default_nettype wire

FILE: rtl/fhc_if.sv
// valid/ready channel interfaces: sample in, colour out, config write
// depends on fhc_pkg
`default_nettype none

interface fhc_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] flow_sample;

  modport source (output valid, output flow_sample, input ready);
  modport sink   (input valid, input flow_sample, output ready);
endinterface

interface fhc_out_if #(parameter int CHANNEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_level;
  logic [CHANNEL_BITS-1:0] green_level;
  logic [CHANNEL_BITS-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

interface fhc_cfg_if #(parameter int SAMPLE_BITS = 16);
  import fhc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [SAMPLE_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/flow_heatmap_color_unit.sv
// Heat colormap: signed flow sample in, RGB word out.
// Channels: in_word carries flow_sample, out_word carries red/green/blue
// levels, cfg_word writes the four thresholds (index 0 min, 1 low, 2 high,
// 3 max; other indexes are dropped). All use valid/ready; a word moves on a
// rising edge with both high. cfg_word is always ready.
// Pipeline: CHANNEL_BITS + 2 register stages: one classify cell, CHANNEL_BITS
// divider cells (one quotient bit each) and the output cell. Throughput: one
// word per cycle while out_word.ready is high; every cell is a registered
// stage with its own valid.
// Stall: when out_word.ready is low, the output word holds, empty cells
// upstream still fill, and in_word.ready drops only once the chain is full.
// Reset: rst_n low clears all cell valids and loads the threshold defaults.
// Thresholds should only change while the chain is empty.
// Depends on fhc_pkg, fhc_if, fhc_classify, fhc_div_cell, fhc_finish.
`default_nettype none

module flow_heatmap_color_unit #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  fhc_in_if.sink    in_word,
  fhc_out_if.source out_word,
  fhc_cfg_if.sink   cfg_word
);
  import fhc_pkg::*;
  `include "flow_heatmap_color_unit_macros.svh"

  localparam int SB = SAMPLE_BITS;
  localparam int CB = CHANNEL_BITS;
  localparam logic [CB-1:0] FULL = {CB{1'b1}};

  logic signed [SB-1:0] min_r, low_r, high_r, max_r;
  logic [4*SB-1:0]      thr_all;
  logic                 cfg_wr;

  // chain links: entry k is the output of cell k (0 is classify)
  logic      [CB:0]         v_lnk, r_lnk;
  fhc_mode_t                mode_lnk [CB+1];
  logic      [SB-1:0]       off_lnk  [CB+1];
  logic      [SB-1:0]       span_lnk [CB+1];
  logic      [SB-1:0]       rem_lnk  [CB+1];
  logic      [CB-1:0]       quot_lnk [CB+1];

  // threshold registers
  assign cfg_word.ready = 1'b1;
  assign cfg_wr = cfg_word.valid && cfg_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= RST_MIN_LEVEL[SB-1:0];
      low_r  <= RST_LOW_LEVEL[SB-1:0];
      high_r <= RST_HIGH_LEVEL[SB-1:0];
      max_r  <= RST_MAX_LEVEL[SB-1:0];
    end else if (cfg_wr) begin
      case (cfg_word.index)
        CFG_MIN_LEVEL:  min_r  <= cfg_word.data;
        CFG_LOW_LEVEL:  low_r  <= cfg_word.data;
        CFG_HIGH_LEVEL: high_r <= cfg_word.data;
        CFG_MAX_LEVEL:  max_r  <= cfg_word.data;
        default: ;
      endcase
    end
  end

  assign thr_all = {min_r, low_r, high_r, max_r};

  // front cell
  fhc_classify #(.SAMPLE_BITS(SB)) u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_word.valid),
    .up_ready    (in_word.ready),
    .flow_sample (in_word.flow_sample),
    .min_level   (min_r),
    .low_level   (low_r),
    .high_level  (high_r),
    .max_level   (max_r),
    .dn_valid    (v_lnk[0]),
    .dn_ready    (r_lnk[0]),
    .mode        (mode_lnk[0]),
    .offset      (off_lnk[0]),
    .span        (span_lnk[0])
  );

  // division starts with the offset as remainder and an empty quotient
  assign rem_lnk[0]  = off_lnk[0];
  assign quot_lnk[0] = '0;

  // divider cells, one quotient bit each
  for (genvar k = 1; k <= CB; k++) begin : g_cell
    fhc_div_cell #(.SAMPLE_BITS(SB), .CHANNEL_BITS(CB)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v_lnk[k-1]),
      .up_ready (r_lnk[k-1]),
      .mode_i   (mode_lnk[k-1]),
      .off_i    (off_lnk[k-1]),
      .span_i   (span_lnk[k-1]),
      .rem_i    (rem_lnk[k-1]),
      .quot_i   (quot_lnk[k-1]),
      .dn_valid (v_lnk[k]),
      .dn_ready (r_lnk[k]),
      .mode_o   (mode_lnk[k]),
      .off_o    (off_lnk[k]),
      .span_o   (span_lnk[k]),
      .rem_o    (rem_lnk[k]),
      .quot_o   (quot_lnk[k])
    );
  end

  // output cell
  fhc_finish #(.SAMPLE_BITS(SB), .CHANNEL_BITS(CB)) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v_lnk[CB]),
    .up_ready (r_lnk[CB]),
    .mode_i   (mode_lnk[CB]),
    .off_i    (off_lnk[CB]),
    .rem_i    (rem_lnk[CB]),
    .quot_i   (quot_lnk[CB]),
    .dn_valid (out_word.valid),
    .dn_ready (out_word.ready),
    .red_o    (out_word.red_level),
    .green_o  (out_word.green_level),
    .blue_o   (out_word.blue_level)
  );

  // every colour on the map has one channel off
  `FHC_ASSERT_NOW(a_one_channel_off, out_word.valid,
    out_word.red_level == '0 || out_word.green_level == '0 || out_word.blue_level == '0,
    "no channel off in output colour")
  // every colour on the map has one channel full
  `FHC_ASSERT_NOW(a_one_channel_full, out_word.valid,
    out_word.red_level == FULL || out_word.green_level == FULL || out_word.blue_level == FULL,
    "no channel full in output colour")
  // writes to unknown indexes leave the thresholds alone
  `FHC_ASSERT_NEXT(a_bad_index_ignored, cfg_wr && cfg_word.index > CFG_MAX_LEVEL,
    $stable(thr_all), "threshold changed by out-of-range write")

endmodule

`default_nettype wire

FILE: rtl/fhc_classify.sv
// front cell: picks the colour segment and the fade offset and span
// depends on fhc_pkg
`default_nettype none

module fhc_classify #(
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [SAMPLE_BITS-1:0] flow_sample,
  input  logic signed [SAMPLE_BITS-1:0] min_level,
  input  logic signed [SAMPLE_BITS-1:0] low_level,
  input  logic signed [SAMPLE_BITS-1:0] high_level,
  input  logic signed [SAMPLE_BITS-1:0] max_level,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output fhc_pkg::fhc_mode_t            mode,
  output logic [SAMPLE_BITS-1:0]        offset,
  output logic [SAMPLE_BITS-1:0]        span
);
  import fhc_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic signed [SB:0]   f_x, mn_x, lo_x, hi_x, mx_x;
  logic signed [SB:0]   d_min, d_low, d_high, d_max;
  logic signed [SB:0]   span_lo, span_hi, span_mid;
  logic [SB+1:0]        twice, span_mid_w, mid_off;
  logic                 below_mid;
  fhc_mode_t            mode_nxt;
  logic [SB-1:0]        off_nxt, span_nxt;

  logic                 valid_r;
  fhc_mode_t            mode_r;
  logic [SB-1:0]        off_r, span_r;

  // differences against each threshold
  always_comb begin
    f_x        = {flow_sample[SB-1], flow_sample};
    mn_x       = {min_level[SB-1], min_level};
    lo_x       = {low_level[SB-1], low_level};
    hi_x       = {high_level[SB-1], high_level};
    mx_x       = {max_level[SB-1], max_level};
    d_min      = f_x - mn_x;
    d_low      = f_x - lo_x;
    d_high     = f_x - hi_x;
    d_max      = f_x - mx_x;
    span_lo    = lo_x - mn_x;
    span_hi    = mx_x - hi_x;
    span_mid   = hi_x - lo_x;
    twice      = {d_low, 1'b0};
    span_mid_w = {span_mid[SB], span_mid};
    below_mid  = twice < span_mid_w;
    mid_off    = twice - span_mid_w;
  end

  // segment select in the tested order
  always_comb begin
    mode_nxt = MODE_BLUE;
    off_nxt  = '0;
    span_nxt = {{(SB-1){1'b0}}, 1'b1};
    if (d_min[SB]) begin
      mode_nxt = MODE_BLUE;
    end else if (!d_max[SB]) begin
      mode_nxt = MODE_RED;
    end else if (d_low[SB]) begin
      mode_nxt = MODE_G_UP;
      off_nxt  = d_min[SB-1:0];
      span_nxt = span_lo[SB-1:0];
    end else if (!d_high[SB]) begin
      mode_nxt = MODE_G_DOWN;
      off_nxt  = d_high[SB-1:0];
      span_nxt = span_hi[SB-1:0];
    end else if (below_mid) begin
      mode_nxt = MODE_B_DOWN;
      off_nxt  = twice[SB-1:0];
      span_nxt = span_mid[SB-1:0];
    end else begin
      mode_nxt = MODE_R_UP;
      off_nxt  = mid_off[SB-1:0];
      span_nxt = span_mid[SB-1:0];
    end
  end

  assign up_ready = !valid_r || dn_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mode_r <= mode_nxt;
      off_r  <= off_nxt;
      span_r <= span_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign mode     = mode_r;
  assign offset   = off_r;
  assign span     = span_r;

endmodule

`default_nettype wire

FILE: rtl/fhc_div_cell.sv
// divider cell: one quotient bit of offset/span per cell, registered
// depends on fhc_pkg and flow_heatmap_color_unit_macros.svh
`default_nettype none

module fhc_div_cell #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  fhc_pkg::fhc_mode_t      mode_i,
  input  logic [SAMPLE_BITS-1:0]  off_i,
  input  logic [SAMPLE_BITS-1:0]  span_i,
  input  logic [SAMPLE_BITS-1:0]  rem_i,
  input  logic [CHANNEL_BITS-1:0] quot_i,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output fhc_pkg::fhc_mode_t      mode_o,
  output logic [SAMPLE_BITS-1:0]  off_o,
  output logic [SAMPLE_BITS-1:0]  span_o,
  output logic [SAMPLE_BITS-1:0]  rem_o,
  output logic [CHANNEL_BITS-1:0] quot_o
);
  import fhc_pkg::*;
  `include "flow_heatmap_color_unit_macros.svh"

  localparam int SB = SAMPLE_BITS;
  localparam int CB = CHANNEL_BITS;

  logic [SB:0]   shifted, diff;
  logic          take;
  logic [SB-1:0] rem_nxt;

  logic          valid_r;
  fhc_mode_t     mode_r;
  logic [SB-1:0] off_r, span_r, rem_r;
  logic [CB-1:0] quot_r;

  // restoring step: double the remainder, subtract span if it fits
  always_comb begin
    shifted = {rem_i, 1'b0};
    diff    = shifted - {1'b0, span_i};
    take    = shifted >= {1'b0, span_i};
    rem_nxt = take ? diff[SB-1:0] : shifted[SB-1:0];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mode_r <= mode_i;
      off_r  <= off_i;
      span_r <= span_i;
      rem_r  <= rem_nxt;
      quot_r <= {quot_i[CB-2:0], take};
    end
  end

  assign dn_valid = valid_r;
  assign mode_o   = mode_r;
  assign off_o    = off_r;
  assign span_o   = span_r;
  assign rem_o    = rem_r;
  assign quot_o   = quot_r;

  // partial remainder must stay below the divisor
  `FHC_ASSERT_NOW(a_rem_below_span, valid_r, rem_r < span_r, "remainder not below span")
  // offset never reaches span, so the quotient fits the channel
  `FHC_ASSERT_NOW(a_off_below_span, valid_r, off_r < span_r, "offset not below span")

endmodule

`default_nettype wire

FILE: rtl/fhc_finish.sv
// last cell: quotient correction and colour assembly into the output register
// depends on fhc_pkg
`default_nettype none

module fhc_finish #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  fhc_pkg::fhc_mode_t      mode_i,
  input  logic [SAMPLE_BITS-1:0]  off_i,
  input  logic [SAMPLE_BITS-1:0]  rem_i,
  input  logic [CHANNEL_BITS-1:0] quot_i,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o
);
  import fhc_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam logic [CB-1:0] FULL = {CB{1'b1}};

  logic [CB-1:0] frac;
  logic [CB-1:0] red_nxt, green_nxt, blue_nxt;

  logic          valid_r;
  logic [CB-1:0] red_r, green_r, blue_r;

  // cells gave floor(2^C*off/span); drop one when remainder is below off
  assign frac = (rem_i >= off_i) ? quot_i : quot_i - {{(CB-1){1'b0}}, 1'b1};

  // colour per segment
  always_comb begin
    case (mode_i)
      MODE_BLUE:   begin red_nxt = '0;    green_nxt = '0;    blue_nxt = FULL;  end
      MODE_RED:    begin red_nxt = FULL;  green_nxt = '0;    blue_nxt = '0;    end
      MODE_G_UP:   begin red_nxt = '0;    green_nxt = frac;  blue_nxt = FULL;  end
      MODE_G_DOWN: begin red_nxt = FULL;  green_nxt = ~frac; blue_nxt = '0;    end
      MODE_B_DOWN: begin red_nxt = '0;    green_nxt = FULL;  blue_nxt = ~frac; end
      MODE_R_UP:   begin red_nxt = frac;  green_nxt = FULL;  blue_nxt = '0;    end
      default:     begin red_nxt = '0;    green_nxt = '0;    blue_nxt = '0;    end
    endcase
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign red_o    = red_r;
  assign green_o  = green_r;
  assign blue_o   = blue_r;

endmodule

`default_nettype wire
